[hw/rtl/dtpr_pkg.sv]
// Shared types and constants for the disparity-to-point reprojection block.
// Holds field widths, configuration register codes and reset values.
// No dependencies; every other file of the block imports this package.
package dtpr_pkg;

	// Fixed field widths.
	localparam int DISP_W    = 16;
	localparam int CFG_W     = 32;
	localparam int PRIN_W    = 12;
	localparam int POS_W     = 32;
	localparam int ZPOS_W    = 31;
	localparam int REG_IDX_W = 2;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0]  FOCAL_BASELINE_RST = 32'd2580480;
	localparam logic [CFG_W-1:0]  INV_FOCAL_RST      = 32'd8180846;
	localparam logic [PRIN_W-1:0] PRINCIPAL_U_RST    = 12'd320;
	localparam logic [PRIN_W-1:0] PRINCIPAL_V_RST    = 12'd240;

	// Saturation limits and rounding constant.
	localparam logic [ZPOS_W-1:0] ZPOS_MAX   = '1;
	localparam logic [POS_W-1:0]  POS_MAX    = 32'h7FFF_FFFF;
	localparam logic [POS_W-1:0]  POS_MIN    = 32'h8000_0000;
	localparam logic [64:0]       ROUND_HALF = 65'h0_8000_0000;

	// Configuration register indexes.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_FOCAL_BASELINE = 2'd0,
		REG_INV_FOCAL      = 2'd1,
		REG_PRINCIPAL_U    = 2'd2,
		REG_PRINCIPAL_V    = 2'd3
	} dtpr_reg_t;

	// Per-item flags that travel alongside the datapath.
	typedef struct packed {
		logic bad;
		logic neg_x;
		logic neg_y;
	} dtpr_flags_t;

	localparam int FLAGS_W = $bits(dtpr_flags_t);

endpackage

[hw/rtl/dtpr_divider.sv]
// Pipelined restoring divider: one quotient bit per register stage.
// Carries an opaque side vector alongside each item. Uses dtpr_pkg.
module dtpr_divider #(
	parameter int NUM_W  = 39,
	parameter int SIDE_W = 27
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	output logic                       in_rdy,
	input  logic [NUM_W-1:0]           in_num,
	input  logic [dtpr_pkg::DISP_W-1:0] in_den,
	input  logic [SIDE_W-1:0]          in_side,
	output logic                       out_vld,
	input  logic                       out_rdy,
	output logic [NUM_W-1:0]           out_quo,
	output logic [SIDE_W-1:0]          out_side
);
	import dtpr_pkg::*;

	// Stage k holds the state after k+1 quotient bits have been resolved.
	logic              vld_sk  [NUM_W];
	logic [NUM_W-1:0]  qn_sk   [NUM_W];
	logic [DISP_W-1:0] rem_sk  [NUM_W];
	logic [DISP_W-1:0] den_sk  [NUM_W];
	logic [SIDE_W-1:0] side_sk [NUM_W];
	logic              rdy     [NUM_W+1];

	assign rdy[NUM_W] = out_rdy;
	assign in_rdy     = rdy[0];

	genvar k;
	generate
		for (k = 0; k < NUM_W; k++) begin : g_stage
			logic              prev_vld;
			logic [NUM_W-1:0]  prev_qn;
			logic [DISP_W-1:0] prev_rem;
			logic [DISP_W-1:0] prev_den;
			logic [SIDE_W-1:0] prev_side;
			logic [DISP_W:0]   trial;
			logic [DISP_W:0]   diff;
			logic              take;

			if (k == 0) begin : g_first
				assign prev_vld  = in_vld;
				assign prev_qn   = in_num;
				assign prev_rem  = '0;
				assign prev_den  = in_den;
				assign prev_side = in_side;
			end else begin : g_next
				assign prev_vld  = vld_sk[k-1];
				assign prev_qn   = qn_sk[k-1];
				assign prev_rem  = rem_sk[k-1];
				assign prev_den  = den_sk[k-1];
				assign prev_side = side_sk[k-1];
			end

			// A stage can load when it is empty or its content moves on.
			assign rdy[k] = !vld_sk[k] || rdy[k+1];

			// Shift in the next numerator bit and try to subtract the divisor.
			assign trial = {prev_rem, prev_qn[NUM_W-1]};
			assign diff  = trial - {1'b0, prev_den};
			assign take  = (trial >= {1'b0, prev_den});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_sk[k] <= 1'b0;
				end else if (rdy[k]) begin
					vld_sk[k] <= prev_vld;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k] && prev_vld) begin
					rem_sk[k]  <= take ? diff[DISP_W-1:0] : trial[DISP_W-1:0];
					qn_sk[k]   <= {prev_qn[NUM_W-2:0], take};
					den_sk[k]  <= prev_den;
					side_sk[k] <= prev_side;
				end
			end
		end
	endgenerate

	assign out_vld  = vld_sk[NUM_W-1];
	assign out_quo  = qn_sk[NUM_W-1];
	assign out_side = side_sk[NUM_W-1];

endmodule

[hw/rtl/dtpr_project.sv]
// Projection back end: scales depth by pixel offset and inverse focal length.
// Five register stages for two lanes (x and y), last stage is the output register.
// Uses dtpr_pkg for widths, limits and the flag struct.
module dtpr_project #(
	parameter int NUM_W = 39,
	parameter int MAG_W = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	output logic                        in_rdy,
	input  logic [NUM_W-1:0]            in_quo,
	input  logic [MAG_W-1:0]            in_mag_x,
	input  logic [MAG_W-1:0]            in_mag_y,
	input  dtpr_pkg::dtpr_flags_t       in_flags,
	input  logic [dtpr_pkg::CFG_W-1:0]  inv_focal,
	output logic                        out_vld,
	input  logic                        out_rdy,
	output logic [dtpr_pkg::POS_W-1:0]  x_pos,
	output logic [dtpr_pkg::POS_W-1:0]  y_pos,
	output logic [dtpr_pkg::ZPOS_W-1:0] z_pos,
	output logic                        invalid
);
	import dtpr_pkg::*;

	localparam int ZH_W = NUM_W - 32;
	localparam int PL_W = 32 + MAG_W;
	localparam int PH_W = ZH_W + MAG_W;
	localparam int M_W  = NUM_W + MAG_W;
	localparam int MH_W = M_W - 32;
	localparam int A_W  = MH_W + 32;
	localparam int R_W  = A_W + 1;

	// Stage valid bits and the ready chain.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5   = !vld_s5 || out_rdy;
	assign rdy4   = !vld_s4 || rdy5;
	assign rdy3   = !vld_s3 || rdy4;
	assign rdy2   = !vld_s2 || rdy3;
	assign rdy1   = !vld_s1 || rdy2;
	assign in_rdy = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_vld;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	// Flags and saturated depth ride along to the output stage.
	dtpr_flags_t       flags_s1, flags_s2, flags_s3, flags_s4;
	logic [ZPOS_W-1:0] zsat_s1, zsat_s2, zsat_s3, zsat_s4;
	logic [ZPOS_W-1:0] zsat_in;

	assign zsat_in = (|in_quo[NUM_W-1:ZPOS_W]) ? ZPOS_MAX : in_quo[ZPOS_W-1:0];

	always_ff @(posedge clk) begin
		if (rdy1 && in_vld) begin
			flags_s1 <= in_flags;
			zsat_s1  <= zsat_in;
		end
		if (rdy2 && vld_s1) begin
			flags_s2 <= flags_s1;
			zsat_s2  <= zsat_s1;
		end
		if (rdy3 && vld_s2) begin
			flags_s3 <= flags_s2;
			zsat_s3  <= zsat_s2;
		end
		if (rdy4 && vld_s3) begin
			flags_s4 <= flags_s3;
			zsat_s4  <= zsat_s3;
		end
	end

	// Lane 0 is x, lane 1 is y.
	logic [MAG_W-1:0] mag    [2];
	logic             neg_s4 [2];
	logic [POS_W-1:0] pos_s5 [2];

	assign mag[0]    = in_mag_x;
	assign mag[1]    = in_mag_y;
	assign neg_s4[0] = flags_s4.neg_x;
	assign neg_s4[1] = flags_s4.neg_y;

	genvar l;
	generate
		for (l = 0; l < 2; l++) begin : g_lane
			logic [PL_W-1:0]  pl_s1;
			logic [PH_W-1:0]  ph_s1;
			logic [M_W-1:0]   m_s2;
			logic [A_W-1:0]   a_s3;
			logic [63:0]      b_s3;
			logic [R_W-1:0]   r_s4;
			logic [64:0]      bsum;
			logic             big_pos;
			logic             big_neg;
			logic [POS_W-1:0] pos_nxt;

			// Round the low product half up and fold it into the high product.
			assign bsum = {1'b0, b_s3} + ROUND_HALF;

			// Clamp the magnitude to the signed range and apply the sign.
			assign big_pos = |r_s4[R_W-1:POS_W-1];
			assign big_neg = (|r_s4[R_W-1:POS_W]) || (r_s4[POS_W-1] && (|r_s4[POS_W-2:0]));

			always_comb begin
				if (flags_s4.bad) begin
					pos_nxt = '0;
				end else if (neg_s4[l]) begin
					pos_nxt = big_neg ? POS_MIN : (POS_W'(0) - r_s4[POS_W-1:0]);
				end else begin
					pos_nxt = big_pos ? POS_MAX : r_s4[POS_W-1:0];
				end
			end

			always_ff @(posedge clk) begin
				// Depth times offset, split into 32-bit and upper partial products.
				if (rdy1 && in_vld) begin
					pl_s1 <= PL_W'(in_quo[31:0]) * PL_W'(mag[l]);
					ph_s1 <= PH_W'(in_quo[NUM_W-1:32]) * PH_W'(mag[l]);
				end
				// Recombine the partial products.
				if (rdy2 && vld_s1) begin
					m_s2 <= (M_W'(ph_s1) << 32) + M_W'(pl_s1);
				end
				// Scale both halves by the inverse focal length.
				if (rdy3 && vld_s2) begin
					a_s3 <= A_W'(m_s2[M_W-1:32]) * A_W'(inv_focal);
					b_s3 <= 64'(m_s2[31:0]) * 64'(inv_focal);
				end
				if (rdy4 && vld_s3) begin
					r_s4 <= R_W'(a_s3) + R_W'(bsum[64:32]);
				end
				if (rdy5 && vld_s4) begin
					pos_s5[l] <= pos_nxt;
				end
			end
		end
	endgenerate

	// Output register for depth and flag.
	logic [ZPOS_W-1:0] z_s5;
	logic              bad_s5;

	always_ff @(posedge clk) begin
		if (rdy5 && vld_s4) begin
			z_s5   <= flags_s4.bad ? '0 : zsat_s4;
			bad_s5 <= flags_s4.bad;
		end
	end

	assign out_vld = vld_s5;
	assign x_pos   = pos_s5[0];
	assign y_pos   = pos_s5[1];
	assign z_pos   = z_s5;
	assign invalid = bad_s5;

endmodule

[hw/rtl/disparity_to_point_reprojection.sv]
// Top level of the stereo disparity to 3D point reprojection block.
// Instantiates dtpr_divider and dtpr_project; uses dtpr_pkg.
//
// Usage: one disparity pixel enters per transfer on the s_axis channel with its
// column and row; tuser carries the missing-measurement flag. Each pixel gives
// exactly one point on the m_axis channel: x, y (signed Q16.16) and z (Q16.16),
// with tuser set when the disparity is missing or zero (positions then zero).
// Camera constants are written through the cfg port while no pixels are in
// flight; an index beyond the register list is ignored.
// The pipeline has one entry stage, one stage per quotient bit of the pipelined
// restoring divider (33 + DISP_FRAC_BITS), and five multiply, rounding and
// saturation stages, the last being the output register. One pixel is taken
// per cycle while the receiver is not stalling.
// Reset clears all stage valid bits and restores the default camera constants.
// When the receiver stalls, results collect in the pipeline: each empty stage
// still takes data, so input is refused only once every stage from the entry
// register to the output register holds a pixel. Nothing is lost or repeated.
module disparity_to_point_reprojection #(
	parameter int COORD_BITS     = 12,
	parameter int DISP_FRAC_BITS = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// tdata: pixel_column, pixel_row, disparity (from bit 0 up), zero fill
	input  logic [((2*COORD_BITS+dtpr_pkg::DISP_W+7)/8)*8-1:0] s_axis_tdata,
	// tuser: disparity_invalid
	input  logic                           s_axis_tuser,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// tdata: x_position, y_position, z_position (from bit 0 up), zero fill
	output logic [95:0]                    m_axis_tdata,
	// tuser: point_invalid
	output logic                           m_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic                           cfg_we,
	input  logic [dtpr_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [dtpr_pkg::CFG_W-1:0]     cfg_wdata
);
	import dtpr_pkg::*;

	localparam int NUM_W  = 33 + DISP_FRAC_BITS;
	localparam int PU_W   = (COORD_BITS > PRIN_W) ? COORD_BITS : PRIN_W;
	localparam int SIDE_W = FLAGS_W + 2 * COORD_BITS;

	// Configuration registers.
	logic [CFG_W-1:0]  focal_baseline_q;
	logic [CFG_W-1:0]  inv_focal_q;
	logic [PRIN_W-1:0] principal_u_q;
	logic [PRIN_W-1:0] principal_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_baseline_q <= FOCAL_BASELINE_RST;
			inv_focal_q      <= INV_FOCAL_RST;
			principal_u_q    <= PRINCIPAL_U_RST;
			principal_v_q    <= PRINCIPAL_V_RST;
		end else if (cfg_we) begin
			case (dtpr_reg_t'(cfg_addr))
				REG_FOCAL_BASELINE: focal_baseline_q <= cfg_wdata;
				REG_INV_FOCAL:      inv_focal_q      <= cfg_wdata;
				REG_PRINCIPAL_U:    principal_u_q    <= cfg_wdata[PRIN_W-1:0];
				REG_PRINCIPAL_V:    principal_v_q    <= cfg_wdata[PRIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Principal point taken at the coordinate width.
	logic [PU_W-1:0]       pu_ext, pv_ext;
	logic [COORD_BITS-1:0] pu_c, pv_c;

	assign pu_ext = PU_W'(principal_u_q);
	assign pv_ext = PU_W'(principal_v_q);
	assign pu_c   = pu_ext[COORD_BITS-1:0];
	assign pv_c   = pv_ext[COORD_BITS-1:0];

	// Unpack the input transfer.
	logic [COORD_BITS-1:0] col, row;
	logic [DISP_W-1:0]     disp;

	assign col  = s_axis_tdata[COORD_BITS-1:0];
	assign row  = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
	assign disp = s_axis_tdata[2*COORD_BITS+DISP_W-1:2*COORD_BITS];

	// Entry stage: rounded numerator, pixel offsets and their signs.
	dtpr_flags_t           flags_in;
	logic [NUM_W-1:0]      num_in;
	logic [COORD_BITS-1:0] mag_x_in, mag_y_in;

	assign flags_in.bad   = s_axis_tuser || (disp == '0);
	assign flags_in.neg_x = (col < pu_c);
	assign flags_in.neg_y = (row < pv_c);
	assign mag_x_in       = flags_in.neg_x ? (pu_c - col) : (col - pu_c);
	assign mag_y_in       = flags_in.neg_y ? (pv_c - row) : (row - pv_c);
	assign num_in         = (NUM_W'(focal_baseline_q) << DISP_FRAC_BITS)
	                        + NUM_W'(disp >> 1);

	logic                  vld_s1;
	logic [NUM_W-1:0]      num_s1;
	logic [DISP_W-1:0]     den_s1;
	logic [COORD_BITS-1:0] mag_x_s1, mag_y_s1;
	dtpr_flags_t           flags_s1;
	logic                  div_in_rdy;

	assign s_axis_tready = !vld_s1 || div_in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			num_s1   <= num_in;
			den_s1   <= disp;
			mag_x_s1 <= mag_x_in;
			mag_y_s1 <= mag_y_in;
			flags_s1 <= flags_in;
		end
	end

	// Depth division.
	logic              div_out_vld;
	logic              prj_in_rdy;
	logic [NUM_W-1:0]  div_quo;
	logic [SIDE_W-1:0] div_side;

	dtpr_divider #(
		.NUM_W  (NUM_W),
		.SIDE_W (SIDE_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.in_rdy   (div_in_rdy),
		.in_num   (num_s1),
		.in_den   (den_s1),
		.in_side  ({flags_s1, mag_x_s1, mag_y_s1}),
		.out_vld  (div_out_vld),
		.out_rdy  (prj_in_rdy),
		.out_quo  (div_quo),
		.out_side (div_side)
	);

	dtpr_flags_t           div_flags;
	logic [COORD_BITS-1:0] div_mag_x, div_mag_y;

	assign div_flags = dtpr_flags_t'(div_side[SIDE_W-1:2*COORD_BITS]);
	assign div_mag_x = div_side[2*COORD_BITS-1:COORD_BITS];
	assign div_mag_y = div_side[COORD_BITS-1:0];

	// Lateral projection and output register.
	logic [POS_W-1:0]  x_pos, y_pos;
	logic [ZPOS_W-1:0] z_pos;
	logic              pt_invalid;

	dtpr_project #(
		.NUM_W (NUM_W),
		.MAG_W (COORD_BITS)
	) u_project (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (div_out_vld),
		.in_rdy    (prj_in_rdy),
		.in_quo    (div_quo),
		.in_mag_x  (div_mag_x),
		.in_mag_y  (div_mag_y),
		.in_flags  (div_flags),
		.inv_focal (inv_focal_q),
		.out_vld   (m_axis_tvalid),
		.out_rdy   (m_axis_tready),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.z_pos     (z_pos),
		.invalid   (pt_invalid)
	);

	assign m_axis_tdata = 96'({z_pos, y_pos, x_pos});
	assign m_axis_tuser = pt_invalid;

`ifndef SYNTH
	// An accepted pixel always lands in the entry stage.
	a_entry_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_s1)
		else $error("entry stage did not capture an accepted pixel");

	// A stalled entry stage keeps its item.
	a_entry_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !div_in_rdy |=> vld_s1 && $stable(num_s1) && $stable(flags_s1))
		else $error("entry stage changed while stalled");

	// An invalid point carries all-zero positions.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("invalid point with nonzero position");
`endif

endmodule
